### hdl/tdf_pkg.sv
// shared types and constants of the trial division factorizer
`default_nettype none

package tdf_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

endpackage

`default_nettype wire

### hdl/trial_division_factorizer.sv
// trial division factorizer with a shared bit-serial divider
//
// Input channel: in_valid_i / in_stall_o with value_i. A beat is taken when
// valid is high and stall is low. in_stall_o is high from the accepted beat
// until its final result has been loaded into the output register, so one
// value is factored at a time, and the next value waits for that load.
// Output channel: out_valid_o / out_stall_i with factor_o, last_o, status_o.
// One beat per prime factor in ascending order; last_o marks the final one.
// Values below two give a single beat with factor 0 and status 1.
// Each trial division runs the restoring divider over all VALUE_WIDTH
// quotient bits, one quotient bit a cycle, then an evaluate step. A divisor
// that divides is tried again on the cofactor, and every factor found passes
// through the emit state, which waits until the output register frees. Trial
// divisors run from two up to the square root of the remaining cofactor, so a
// value of VALUE_WIDTH bits takes up to about 2^(VALUE_WIDTH/2) trials.
// A stalled output holds its beat; the sequencer waits with the next factor
// until the output register frees.
// Reset clears the sequencer and the output valid; the block is idle and
// ready for a value right after reset.
`default_nettype none

module trial_division_factorizer
  import tdf_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  input  wire value_t value_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output value_t      factor_o,
  output logic        last_o,
  output logic        status_o
);

  state_e state_q, state_d;
  value_t rem_q, rem_d;
  value_t div_q, div_d;
  value_t quo_q, quo_d;
  value_t par_q, par_d;
  cnt_t   cnt_q, cnt_d;
  value_t pend_factor_q, pend_factor_d;
  logic   pend_last_q, pend_last_d;
  logic   pend_status_q, pend_status_d;
  logic   out_valid_q, out_valid_d;
  value_t factor_q;
  logic   last_q, status_q;

  logic                 slot_free;
  logic                 out_load;
  logic [VALUE_WIDTH:0] trial;
  logic [VALUE_WIDTH:0] diff;
  logic                 fits;

  assign slot_free = !out_valid_q || !out_stall_i;

  // one restoring divide step
  assign trial = {par_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    state_d       = state_q;
    rem_d         = rem_q;
    div_d         = div_q;
    quo_d         = quo_q;
    par_d         = par_q;
    cnt_d         = cnt_q;
    pend_factor_d = pend_factor_q;
    pend_last_d   = pend_last_q;
    pend_status_d = pend_status_q;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (value_i < value_t'(2)) begin
            pend_factor_d = '0;
            pend_last_d   = 1'b1;
            pend_status_d = 1'b1;
            state_d       = ST_EMIT;
          end else begin
            rem_d   = value_i;
            div_d   = value_t'(2);
            quo_d   = value_i;
            par_d   = '0;
            cnt_d   = cnt_t'(VALUE_WIDTH - 1);
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        par_d = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
        cnt_d = cnt_q - cnt_t'(1);
        if (cnt_q == '0) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (div_q <= quo_q) begin
          if (par_q == '0) begin
            rem_d         = quo_q;
            pend_factor_d = div_q;
            pend_last_d   = (quo_q == value_t'(1));
            pend_status_d = 1'b0;
            state_d       = ST_EMIT;
          end else begin
            div_d   = div_q + value_t'(1);
            quo_d   = rem_q;
            par_d   = '0;
            cnt_d   = cnt_t'(VALUE_WIDTH - 1);
            state_d = ST_DIV;
          end
        end else begin
          // cofactor left over is prime
          pend_factor_d = rem_q;
          pend_last_d   = 1'b1;
          pend_status_d = 1'b0;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (pend_last_q) begin
            state_d = ST_IDLE;
          end else begin
            quo_d   = rem_q;
            par_d   = '0;
            cnt_d   = cnt_t'(VALUE_WIDTH - 1);
            state_d = ST_DIV;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    div_q         <= div_d;
    quo_q         <= quo_d;
    par_q         <= par_d;
    pend_factor_q <= pend_factor_d;
    pend_last_q   <= pend_last_d;
    pend_status_q <= pend_status_d;
    if (out_load) begin
      factor_q <= pend_factor_q;
      last_q   <= pend_last_q;
      status_q <= pend_status_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

### hdl/tdf_checker.sv
// port-level checks of the trial division factorizer and their binding
`default_nettype none

module tdf_checker
  import tdf_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   in_valid_i,
  input wire logic   in_stall_o,
  input wire logic   out_valid_o,
  input wire logic   out_stall_i,
  input wire value_t factor_o,
  input wire logic   last_o,
  input wire logic   status_o
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(factor_o) &&
      $stable(last_o) && $stable(status_o))
    else $error("stalled output beat changed");

  // busy after taking a value
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a value is in work");

  // no-factor beat is a single final beat with factor zero
  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && (factor_o == '0))
    else $error("bad no-factor beat");

  // real factors are at least two
  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> (factor_o >= value_t'(2)))
    else $error("factor below two");

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .factor_o    (factor_o),
  .last_o      (last_o),
  .status_o    (status_o)
);

`default_nettype wire
